>>> rtl/samb_pkg.sv
// ----------------------------------------------------------------------------
// Scaled alpha mask blender package
// Shared types, register indexes, operation codes and helper functions.
// ----------------------------------------------------------------------------
package samb_pkg;

  localparam int CANVAS_WIDTH  = 1024;
  localparam int CANVAS_HEIGHT = 1024;

  // Quotient bits of the tap-and-weight division: 8 integer, 8 fraction.
  localparam int QW = 16;
  // Partial remainder width.
  localparam int RW = 28;
  // Quotient bits resolved in each divider stage.
  localparam int DIV_STEPS = 4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd250;
  localparam logic [7:0] ALPHA_FULL   = 8'd255;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_BLEND = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_MASK_WIDTH   = 3'd0,
    REG_MASK_HEIGHT  = 3'd1,
    REG_BOX_WIDTH    = 3'd2,
    REG_BOX_HEIGHT   = 3'd3,
    REG_TINT_COLOR   = 3'd4,
    REG_GLOBAL_ALPHA = 3'd5,
    REG_ORIGIN_X     = 3'd6,
    REG_ORIGIN_Y     = 3'd7
  } reg_index_t;

  typedef struct packed {
    op_t         op;
    logic [13:0] addr;
    logic [7:0]  val;
    logic        skip;
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [15:0] bg;
  } payload_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
  } div_t;

  // Resolves DIV_STEPS quotient bits of a restoring division, starting at bit hi.
  function automatic div_t div_steps(div_t s, logic [11:0] d, int hi);
    div_t          r;
    logic [RW-1:0] sh;
    int            i;
    r = s;
    for (int j = 0; j < DIV_STEPS; j++) begin
      i = hi - j;
      if (i >= 0) begin
        sh = RW'(d) << i;
        if (r.rem >= sh) begin
          r.rem  = r.rem - sh;
          r.q[i] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

>>> rtl/scaled_alpha_mask_blender.sv
// ----------------------------------------------------------------------------
// Scaled alpha mask blender
// Bilinear sampling of a stored coverage mask scaled into a destination box,
// then a tinted RGB565 blend over the background pixel.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while m_tready is high; stages advance
// independently, so bubbles are squeezed out while the output waits.
// Loads write the coverage memories in stage 8 and produce no output beat.
// Reset (rst, synchronous) clears valid bits and resets configuration registers;
// the coverage memories are not cleared and read as undefined until written.
module scaled_alpha_mask_blender #(
  parameter int MASK_MAX_W = 128,
  parameter int MASK_MAX_H = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mask_address[13:0], mask_value[21:14], box_col[31:22], box_row[41:32],
  // background_pixel[57:42], zero fill[63:58]
  input  logic [63:0] s_tdata,
  // operation[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // canvas_x[9:0], canvas_y[19:10], new_pixel[35:20], write_pixel[36],
  // zero fill[39:37]
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int DEPTH = MASK_MAX_W * MASK_MAX_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NS    = 13;

  logic [7:0]         mask_width, mask_height, global_alpha;
  logic [10:0]        box_width, box_height;
  logic [23:0]        tint_color;
  logic signed [10:0] origin_x, origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width   <= 8'd1;
      mask_height  <= 8'd1;
      box_width    <= 11'd1;
      box_height   <= 11'd1;
      tint_color   <= 24'd0;
      global_alpha <= 8'd255;
      origin_x     <= 11'sd0;
      origin_y     <= 11'sd0;
    end else if (cfg_we) begin
      case (samb_pkg::reg_index_t'(cfg_index))
        samb_pkg::REG_MASK_WIDTH:   mask_width   <= cfg_data[7:0];
        samb_pkg::REG_MASK_HEIGHT:  mask_height  <= cfg_data[7:0];
        samb_pkg::REG_BOX_WIDTH:    box_width    <= cfg_data[10:0];
        samb_pkg::REG_BOX_HEIGHT:   box_height   <= cfg_data[10:0];
        samb_pkg::REG_TINT_COLOR:   tint_color   <= cfg_data;
        samb_pkg::REG_GLOBAL_ALPHA: global_alpha <= cfg_data[7:0];
        samb_pkg::REG_ORIGIN_X:     origin_x     <= $signed(cfg_data[10:0]);
        samb_pkg::REG_ORIGIN_Y:     origin_y     <= $signed(cfg_data[10:0]);
        default: ;
      endcase
    end
  end

  // Effective mask size, clamped to the store.
  logic [7:0] mw, mh;
  always_comb begin
    mw = mask_width;
    mh = mask_height;
    if (mask_width == 8'd0) begin
      mw = 8'd1;
    end else if ({3'b0, mask_width} > 11'(MASK_MAX_W)) begin
      mw = 8'(MASK_MAX_W);
    end
    if (mask_height == 8'd0) begin
      mh = 8'd1;
    end else if ({3'b0, mask_height} > 11'(MASK_MAX_H)) begin
      mh = 8'(MASK_MAX_H);
    end
  end

  samb_pkg::payload_t pl [1:NS];

  // Stage handshake: a stage takes a new beat when it is empty or drains.
  logic [1:NS]   v;
  logic [1:NS+1] rdy;
  always_comb begin
    rdy[NS+1] = m_tready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end
  assign s_tready = rdy[1];
  assign m_tvalid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          if (k == 8) begin
            v[k] <= v[k-1] && (pl[k-1].op == samb_pkg::OP_BLEND);
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // Stage 1: box and canvas checks, division numerators.
  logic [9:0]         in_col, in_row;
  logic signed [13:0] cxs, cys;
  logic               outside;
  logic [18:0]        tx, ty;
  logic signed [19:0] nx, ny, nxa, nya;
  logic [11:0]        dx_den, dy_den;
  samb_pkg::payload_t pl_in;

  assign in_col = s_tdata[31:22];
  assign in_row = s_tdata[41:32];
  assign dx_den = {box_width, 1'b0};
  assign dy_den = {box_height, 1'b0};

  always_comb begin
    cxs = $signed({{3{origin_x[10]}}, origin_x}) + $signed({4'b0, in_col});
    cys = $signed({{3{origin_y[10]}}, origin_y}) + $signed({4'b0, in_row});
    outside = ({1'b0, in_col} >= box_width) || ({1'b0, in_row} >= box_height) ||
              (cxs < 14'sd0) || (cxs >= $signed(14'(samb_pkg::CANVAS_WIDTH))) ||
              (cys < 14'sd0) || (cys >= $signed(14'(samb_pkg::CANVAS_HEIGHT)));
    tx  = {8'b0, in_col, 1'b1} * {11'b0, mw};
    ty  = {8'b0, in_row, 1'b1} * {11'b0, mh};
    nx  = $signed({1'b0, tx}) - $signed({9'b0, box_width});
    ny  = $signed({1'b0, ty}) - $signed({9'b0, box_height});
    nxa = nx[19] ? nx + $signed({8'b0, dx_den}) : nx;
    nya = ny[19] ? ny + $signed({8'b0, dy_den}) : ny;
    pl_in.op   = samb_pkg::op_t'(s_tuser);
    pl_in.addr = s_tdata[13:0];
    pl_in.val  = s_tdata[21:14];
    pl_in.skip = outside;
    pl_in.cx   = outside ? 10'd0 : cxs[9:0];
    pl_in.cy   = outside ? 10'd0 : cys[9:0];
    pl_in.bg   = s_tdata[57:42];
  end

  samb_pkg::div_t dvx [1:5];
  samb_pkg::div_t dvy [1:5];
  logic [1:5]     negx, negy;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pl[1]      <= pl_in;
      dvx[1].rem <= samb_pkg::RW'({nxa[18:0], 8'b0});
      dvx[1].q   <= '0;
      dvy[1].rem <= samb_pkg::RW'({nya[18:0], 8'b0});
      dvy[1].q   <= '0;
      negx[1]    <= nx[19];
      negy[1]    <= ny[19];
    end
    for (int k = 2; k <= NS; k++) begin
      if (rdy[k]) begin
        pl[k] <= pl[k-1];
      end
    end
    // Stages 2 to 5: four quotient bits each.
    for (int k = 2; k <= 5; k++) begin
      if (rdy[k]) begin
        dvx[k]  <= samb_pkg::div_steps(dvx[k-1], dx_den,
                                       samb_pkg::QW - 1 - samb_pkg::DIV_STEPS * (k - 2));
        dvy[k]  <= samb_pkg::div_steps(dvy[k-1], dy_den,
                                       samb_pkg::QW - 1 - samb_pkg::DIV_STEPS * (k - 2));
        negx[k] <= negx[k-1];
        negy[k] <= negy[k-1];
      end
    end
  end

  // Stage 6: clamp taps to the mask edges.
  logic [7:0] mwm1, mhm1, tapx, tapy;
  logic [8:0] tapx1, tapy1;
  logic [7:0] xa6, xb6, ya6, yb6, wx6, wy6;

  always_comb begin
    mwm1  = mw - 8'd1;
    mhm1  = mh - 8'd1;
    tapx  = dvx[5].q[15:8];
    tapy  = dvy[5].q[15:8];
    tapx1 = {1'b0, tapx} + 9'd1;
    tapy1 = {1'b0, tapy} + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      xa6 <= negx[5] ? 8'd0 : ((tapx > mwm1) ? mwm1 : tapx);
      xb6 <= negx[5] ? 8'd0 : ((tapx1 > {1'b0, mwm1}) ? mwm1 : tapx1[7:0]);
      ya6 <= negy[5] ? 8'd0 : ((tapy > mhm1) ? mhm1 : tapy);
      yb6 <= negy[5] ? 8'd0 : ((tapy1 > {1'b0, mhm1}) ? mhm1 : tapy1[7:0]);
      wx6 <= dvx[5].q[7:0];
      wy6 <= dvy[5].q[7:0];
    end
  end

  // Stage 7: row base addresses.
  logic [15:0] rba7, rbb7;
  logic [7:0]  xa7, xb7, wx7, wy7;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      rba7 <= ya6 * mw;
      rbb7 <= yb6 * mw;
      xa7  <= xa6;
      xb7  <= xb6;
      wx7  <= wx6;
      wy7  <= wy6;
    end
  end

  // Stage 8: coverage memories. Two copies, each read at two addresses.
  logic [7:0]    mem_a [DEPTH];
  logic [7:0]    mem_b [DEPTH];
  logic [AW-1:0] ra0, ra1, rb0, rb1, wa;
  logic          load_we;
  logic [7:0]    a00, a10, a01, a11, wx8, wy8;

  assign ra0 = AW'(rba7 + {8'b0, xa7});
  assign ra1 = AW'(rba7 + {8'b0, xb7});
  assign rb0 = AW'(rbb7 + {8'b0, xa7});
  assign rb1 = AW'(rbb7 + {8'b0, xb7});
  assign wa  = AW'(pl[7].addr);
  assign load_we = rdy[8] && v[7] && (pl[7].op == samb_pkg::OP_LOAD) &&
                   (32'(pl[7].addr) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_a[wa] <= pl[7].val;
      mem_b[wa] <= pl[7].val;
    end
    if (rdy[8]) begin
      a00 <= mem_a[ra0];
      a10 <= mem_a[ra1];
      a01 <= mem_b[rb0];
      a11 <= mem_b[rb1];
      wx8 <= wx7;
      wy8 <= wy7;
    end
  end

  // Stage 9: horizontal interpolation.
  logic signed [17:0] top9, bot9;
  logic [7:0]         wy9;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      top9 <= $signed({2'b0, a00, 8'b0}) +
              18'($signed({1'b0, a10}) - $signed({1'b0, a00})) * $signed({1'b0, wx8});
      bot9 <= $signed({2'b0, a01, 8'b0}) +
              18'($signed({1'b0, a11}) - $signed({1'b0, a01})) * $signed({1'b0, wx8});
      wy9  <= wy8;
    end
  end

  // Stage 10: vertical interpolation and rounding.
  logic signed [27:0] vsum;
  logic [27:0]        vrnd;
  logic [7:0]         cov10;

  always_comb begin
    vsum = $signed({top9, 8'b0}) +
           28'($signed(28'(bot9) - 28'(top9)) * $signed({1'b0, wy9}));
    vrnd = vsum[27] ? 28'd0 : (28'(vsum) + 28'd32768);
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      cov10 <= vrnd[23:16];
    end
  end

  // Stage 11: coverage times global alpha.
  logic [15:0] prod11;

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      prod11 <= cov10 * global_alpha;
    end
  end

  // Stage 12: divide by 255 through a shift-and-add reciprocal.
  logic [16:0] q255;
  logic [7:0]  a12;

  assign q255 = {1'b0, prod11} + 17'd1 + {9'b0, prod11[15:8]};

  always_ff @(posedge clk) begin
    if (rdy[12]) begin
      a12 <= q255[15:8];
    end
  end

  // Stage 13: tint blend and output register.
  logic [7:0]  fr, fg, fb, br, bgn, bb, ia;
  logic [15:0] mr, mg, mb;
  logic [9:0]  ox, oy;
  logic [15:0] opix;
  logic        owr;

  always_comb begin
    fr  = tint_color[23:16];
    fg  = tint_color[15:8];
    fb  = tint_color[7:0];
    ia  = samb_pkg::ALPHA_FULL - a12;
    br  = {pl[12].bg[15:11], 3'b0};
    bgn = {pl[12].bg[10:5], 2'b0};
    bb  = {pl[12].bg[4:0], 3'b0};
    mr  = fr * a12 + br * ia;
    mg  = fg * a12 + bgn * ia;
    mb  = fb * a12 + bb * ia;
  end

  always_ff @(posedge clk) begin
    if (rdy[13]) begin
      ox  <= pl[12].cx;
      oy  <= pl[12].cy;
      owr <= !pl[12].skip && (a12 != 8'd0);
      if (pl[12].skip || (a12 == 8'd0)) begin
        opix <= pl[12].bg;
      end else if (a12 >= samb_pkg::ALPHA_OPAQUE) begin
        opix <= samb_pkg::pack565(fr, fg, fb);
      end else begin
        opix <= samb_pkg::pack565(mr[15:8], mg[15:8], mb[15:8]);
      end
    end
  end

  assign m_tdata = {3'b0, owr, opix, oy, ox};

  // Loads leave the pipeline at the memory stage.
  a_no_load_past_mem: assert property (@(posedge clk) disable iff (rst)
    v[8] |-> pl[8].op == samb_pkg::OP_BLEND)
    else $error("load beat passed the memory stage");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v[1])
    else $error("accepted beat did not reach stage one");

  a_skip_no_write: assert property (@(posedge clk) disable iff (rst)
    v[NS] && pl[NS].skip |-> !owr)
    else $error("write flagged for a pixel outside box or canvas");

endmodule
